FILE: hw/rtl/imd_pkg.sv
package imd_pkg;

  localparam logic [7:0] HeaderEnd   = 8'h1A;
  localparam int unsigned CylMapBit  = 7;
  localparam int unsigned HeadMapBit = 6;
  localparam logic [7:0] HeadMask    = 8'h3F;
  localparam logic [2:0] MaxSizeCode = 3'd6;
  localparam logic [13:0] BaseSize   = 14'd128;

  typedef enum logic [11:0] {
    PH_SKIP  = 12'b0000_0000_0001,
    PH_MODE  = 12'b0000_0000_0010,
    PH_CYL   = 12'b0000_0000_0100,
    PH_HEAD  = 12'b0000_0000_1000,
    PH_NSEC  = 12'b0000_0001_0000,
    PH_SIZE  = 12'b0000_0010_0000,
    PH_SMAP  = 12'b0000_0100_0000,
    PH_CMAP  = 12'b0000_1000_0000,
    PH_HMAP  = 12'b0001_0000_0000,
    PH_RTYPE = 12'b0010_0000_0000,
    PH_DATA  = 12'b0100_0000_0000,
    PH_FILL  = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_UNAVL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  cylinder;
    logic [5:0]  head_number;
    logic [2:0]  size_code;
    logic [12:0] byte_offset;
    logic [7:0]  value;
    logic        last;
    logic [7:0]  max_cylinder;
    logic [5:0]  max_head;
    logic [7:0]  max_sectors;
  } result_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
    logic [7:0] rd_idx;
  } map_ctrl_t;

endpackage

FILE: hw/rtl/imd_sector_map.sv
module imd_sector_map #(
  parameter int unsigned MAP_DEPTH = 256
) (
  input  logic              clk_i,
  input  imd_pkg::map_ctrl_t ctrl_i,
  input  logic              rd_en_i,
  output logic [7:0]        rd_data_o
);
  import imd_pkg::*;

  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  logic [7:0] mem [MAP_DEPTH];
  logic       wr_in_range;
  logic       rd_in_range;
  logic [7:0] rd_data_q;

  assign wr_in_range = {1'b0, ctrl_i.wr_idx} < 9'(MAP_DEPTH);
  assign rd_in_range = {1'b0, ctrl_i.rd_idx} < 9'(MAP_DEPTH);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && wr_in_range) begin
      mem[ctrl_i.wr_idx[AW-1:0]] <= ctrl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rd_in_range ? mem[ctrl_i.rd_idx[AW-1:0]] : 8'd0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/imd_parse_fsm.sv
module imd_parse_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                new_image_i,
  output logic                emit_o,
  output imd_pkg::result_t    result_o,
  output imd_pkg::map_ctrl_t  map_ctrl_o
);
  import imd_pkg::*;

  phase_e      phase_q, phase_d, ph;
  logic [7:0]  idx_q, idx_d, idx;
  logic [12:0] bc_q, bc_d, bc;
  logic [7:0]  cyl_q, cyl_d, cyl;
  logic [5:0]  hd_q, hd_d, hd;
  logic [7:0]  nsec_q, nsec_d, nsec;
  logic [2:0]  sz_q, sz_d, sz;
  logic        cmp_q, cmp_d, cmp;
  logic        hmp_q, hmp_d, hmp;
  logic [7:0]  mc_q, mc_d, mc;
  logic [5:0]  mh_q, mh_d, mh;
  logic [7:0]  ms_q, ms_d, ms;

  logic        idx_end;
  logic [8:0]  idx_inc;
  logic [13:0] size_bytes;
  logic        data_end;
  kind_e       kind;
  logic [12:0] offset;
  logic [7:0]  value;
  logic        last;

  always_comb begin
    if (new_image_i) begin
      ph = PH_SKIP; idx = '0; bc = '0; cyl = '0; hd = '0; nsec = '0; sz = '0;
      cmp = 1'b0; hmp = 1'b0; mc = '0; mh = '0; ms = '0;
    end else begin
      ph = phase_q; idx = idx_q; bc = bc_q; cyl = cyl_q; hd = hd_q; nsec = nsec_q;
      sz = sz_q; cmp = cmp_q; hmp = hmp_q; mc = mc_q; mh = mh_q; ms = ms_q;
    end
  end

  assign idx_inc    = {1'b0, idx} + 9'd1;
  assign idx_end    = idx_inc >= {1'b0, nsec};
  assign size_bytes = BaseSize << sz;
  assign data_end   = ({1'b0, bc} + 14'd1) >= size_bytes;

  always_comb begin
    phase_d = ph; idx_d = idx; bc_d = bc; cyl_d = cyl; hd_d = hd; nsec_d = nsec;
    sz_d = sz; cmp_d = cmp; hmp_d = hmp; mc_d = mc; mh_d = mh; ms_d = ms;
    emit_o = 1'b0;
    kind   = KIND_DATA;
    offset = '0;
    value  = '0;
    last   = 1'b0;
    map_ctrl_o.wr_en   = 1'b0;
    map_ctrl_o.wr_idx  = idx;
    map_ctrl_o.wr_data = in_byte_i;
    map_ctrl_o.rd_idx  = idx;
    unique case (ph)
      PH_SKIP: begin
        if (in_byte_i == HeaderEnd) phase_d = PH_MODE;
      end
      PH_MODE: phase_d = PH_CYL;
      PH_CYL: begin
        cyl_d   = in_byte_i;
        phase_d = PH_HEAD;
      end
      PH_HEAD: begin
        cmp_d   = in_byte_i[CylMapBit];
        hmp_d   = in_byte_i[HeadMapBit];
        hd_d    = 6'(in_byte_i & HeadMask);
        phase_d = PH_NSEC;
      end
      PH_NSEC: begin
        nsec_d  = in_byte_i;
        phase_d = PH_SIZE;
      end
      PH_SIZE: begin
        sz_d    = (in_byte_i > 8'(MaxSizeCode)) ? MaxSizeCode : in_byte_i[2:0];
        if (cyl > mc) mc_d = cyl;
        if (hd > mh) mh_d = hd;
        if (nsec > ms) ms_d = nsec;
        idx_d   = '0;
        phase_d = (nsec == 8'd0) ? PH_MODE : PH_SMAP;
      end
      PH_SMAP, PH_CMAP, PH_HMAP: begin
        map_ctrl_o.wr_en = (ph == PH_SMAP);
        if (idx_end) begin
          idx_d = '0;
          if (ph == PH_SMAP && cmp) phase_d = PH_CMAP;
          else if (ph != PH_HMAP && hmp) phase_d = PH_HMAP;
          else phase_d = PH_RTYPE;
        end else begin
          idx_d = idx_inc[7:0];
        end
      end
      PH_RTYPE: begin
        if (in_byte_i == 8'd0) begin
          emit_o  = 1'b1;
          kind    = KIND_UNAVL;
          last    = 1'b1;
          idx_d   = idx_end ? 8'd0 : idx_inc[7:0];
          phase_d = idx_end ? PH_MODE : PH_RTYPE;
        end else begin
          bc_d    = '0;
          phase_d = in_byte_i[0] ? PH_DATA : PH_FILL;
        end
      end
      PH_DATA: begin
        emit_o = 1'b1;
        kind   = KIND_DATA;
        offset = bc;
        value  = in_byte_i;
        last   = data_end;
        if (data_end) begin
          bc_d    = '0;
          idx_d   = idx_end ? 8'd0 : idx_inc[7:0];
          phase_d = idx_end ? PH_MODE : PH_RTYPE;
        end else begin
          bc_d = bc + 13'd1;
        end
      end
      PH_FILL: begin
        emit_o  = 1'b1;
        kind    = KIND_FILL;
        value   = in_byte_i;
        last    = 1'b1;
        idx_d   = idx_end ? 8'd0 : idx_inc[7:0];
        phase_d = idx_end ? PH_MODE : PH_RTYPE;
      end
      default: phase_d = PH_SKIP;
    endcase
  end

  assign result_o.kind         = kind;
  assign result_o.cylinder     = cyl;
  assign result_o.head_number  = hd;
  assign result_o.size_code    = sz;
  assign result_o.byte_offset  = offset;
  assign result_o.value        = value;
  assign result_o.last         = last;
  assign result_o.max_cylinder = mc;
  assign result_o.max_head     = mh;
  assign result_o.max_sectors  = ms;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      idx_q   <= '0;
      bc_q    <= '0;
      cyl_q   <= '0;
      hd_q    <= '0;
      nsec_q  <= '0;
      sz_q    <= '0;
      cmp_q   <= 1'b0;
      hmp_q   <= 1'b0;
      mc_q    <= '0;
      mh_q    <= '0;
      ms_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      bc_q    <= bc_d;
      cyl_q   <= cyl_d;
      hd_q    <= hd_d;
      nsec_q  <= nsec_d;
      sz_q    <= sz_d;
      cmp_q   <= cmp_d;
      hmp_q   <= hmp_d;
      mc_q    <= mc_d;
      mh_q    <= mh_d;
      ms_q    <= ms_d;
    end
  end

endmodule

FILE: hw/rtl/imd_out_stage.sv
module imd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             emit_i,
  input  imd_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output imd_pkg::result_t result_o
);
  import imd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = emit_i;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: hw/rtl/imd_disk_image_track_parser.sv
// Channel | Handshake              | Payload
// input   | in_valid_i, in_stall_o | in_byte_i, new_image_i
// output  | out_valid_o, out_stall_i | kind_o .. max_sectors_o, one result per transaction
// One byte per cycle while the input is not stalled: the parser state and the sector map advance in the accept cycle.
// A result appears in the output register in the cycle after its byte is accepted.
// The input stalls only while a held result is stalled downstream.
// Reset clears the parser state and the output valid; the sector map is not cleared.
module imd_disk_image_track_parser #(
  parameter int unsigned MAP_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        new_image_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  cylinder_o,
  output logic [5:0]  head_number_o,
  output logic [7:0]  sector_id_o,
  output logic [2:0]  size_code_o,
  output logic [12:0] byte_offset_o,
  output logic [7:0]  value_o,
  output logic        last_o,
  output logic [7:0]  max_cylinder_o,
  output logic [5:0]  max_head_o,
  output logic [7:0]  max_sectors_o
);
  import imd_pkg::*;

  logic      accept;
  logic      emit;
  result_t   result;
  result_t   result_q;
  map_ctrl_t map_ctrl;
  map_ctrl_t map_ctrl_gated;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  imd_parse_fsm u_fsm (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .in_byte_i,
    .new_image_i,
    .emit_o      (emit),
    .result_o    (result),
    .map_ctrl_o  (map_ctrl)
  );

  always_comb begin
    map_ctrl_gated       = map_ctrl;
    map_ctrl_gated.wr_en = map_ctrl.wr_en && accept;
  end

  imd_sector_map #(.MAP_DEPTH(MAP_DEPTH)) u_map (
    .clk_i,
    .ctrl_i    (map_ctrl_gated),
    .rd_en_i   (accept && emit),
    .rd_data_o (sector_id_o)
  );

  imd_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i      (accept),
    .emit_i      (emit),
    .result_i    (result),
    .out_stall_i,
    .out_valid_o,
    .result_o    (result_q)
  );

  assign kind_o         = result_q.kind;
  assign cylinder_o     = result_q.cylinder;
  assign head_number_o  = result_q.head_number;
  assign size_code_o    = result_q.size_code;
  assign byte_offset_o  = result_q.byte_offset;
  assign value_o        = result_q.value;
  assign last_o         = result_q.last;
  assign max_cylinder_o = result_q.max_cylinder;
  assign max_head_o     = result_q.max_head;
  assign max_sectors_o  = result_q.max_sectors;

`ifndef SYNTHESIS
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_record_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> (last_o && byte_offset_o == 13'd0))
    else $error("fill or unavailable record not final");

  a_size_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (size_code_o <= MaxSizeCode))
    else $error("size code above saturation");

  a_unavl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_UNAVL) |-> (value_o == 8'd0))
    else $error("unavailable record carries a value");

  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_DATA && last_o) |->
      ({1'b0, byte_offset_o} == (BaseSize << size_code_o) - 14'd1))
    else $error("last data byte at wrong offset");
`endif

endmodule

FILE: tb/imd_track_check_pkg.sv
package imd_track_check_pkg;

  import imd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cylinder;
    logic [5:0]  head_number;
    logic [7:0]  sector_id;
    logic [2:0]  size_code;
    logic [12:0] byte_offset;
    logic [7:0]  value;
    logic        last;
    logic [7:0]  max_cylinder;
    logic [5:0]  max_head;
    logic [7:0]  max_sectors;
  } sector_result_t;

  class track_scoreboard;
    phase_e         state;
    logic [7:0]     sector_ids [256];
    logic [7:0]     rec_index;
    logic [12:0]    data_offset;
    logic [7:0]     trk_cylinder;
    logic [5:0]     trk_head;
    logic [7:0]     trk_sectors;
    logic [2:0]     trk_size;
    logic           cyl_map_on;
    logic           head_map_on;
    logic [7:0]     max_cyl;
    logic [5:0]     max_hd;
    logic [7:0]     max_secs;
    sector_result_t expected [$];
    int             failures;

    function new();
      foreach (sector_ids[i]) sector_ids[i] = '0;
      failures = 0;
      clear_track();
    endfunction

    function void clear_track();
      state        = PH_SKIP;
      rec_index    = '0;
      data_offset  = '0;
      trk_cylinder = '0;
      trk_head     = '0;
      trk_sectors  = '0;
      trk_size     = '0;
      cyl_map_on   = 1'b0;
      head_map_on  = 1'b0;
      max_cyl      = '0;
      max_hd       = '0;
      max_secs     = '0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push_result(logic [1:0] kind, logic [12:0] offset, logic [7:0] val,
                              logic last);
      sector_result_t r;
      r.kind         = kind;
      r.cylinder     = trk_cylinder;
      r.head_number  = trk_head;
      r.sector_id    = sector_ids[rec_index];
      r.size_code    = trk_size;
      r.byte_offset  = offset;
      r.value        = val;
      r.last         = last;
      r.max_cylinder = max_cyl;
      r.max_head     = max_hd;
      r.max_sectors  = max_secs;
      expected.insert(expected.size(), r);
    endfunction

    function void advance_sector();
      if (int'(rec_index) + 1 >= int'(trk_sectors)) begin
        rec_index = '0;
        state     = PH_MODE;
      end else begin
        rec_index++;
        state = PH_RTYPE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic restart);
      if (restart) clear_track();
      case (state)
        PH_SKIP: begin
          if (b == HeaderEnd) state = PH_MODE;
        end
        PH_MODE: state = PH_CYL;
        PH_CYL: begin
          trk_cylinder = b;
          state = PH_HEAD;
        end
        PH_HEAD: begin
          cyl_map_on  = b[CylMapBit];
          head_map_on = b[HeadMapBit];
          trk_head    = b[5:0];
          state       = PH_NSEC;
        end
        PH_NSEC: begin
          trk_sectors = b;
          state = PH_SIZE;
        end
        PH_SIZE: begin
          trk_size = (b > 8'(MaxSizeCode)) ? MaxSizeCode : b[2:0];
          if (trk_cylinder > max_cyl) max_cyl = trk_cylinder;
          if (trk_head > max_hd) max_hd = trk_head;
          if (trk_sectors > max_secs) max_secs = trk_sectors;
          rec_index = '0;
          state = (trk_sectors == 8'd0) ? PH_MODE : PH_SMAP;
        end
        PH_SMAP, PH_CMAP, PH_HMAP: begin
          if (state == PH_SMAP) sector_ids[rec_index] = b;
          if (int'(rec_index) + 1 >= int'(trk_sectors)) begin
            rec_index = '0;
            if (state == PH_SMAP && cyl_map_on) state = PH_CMAP;
            else if (state != PH_HMAP && head_map_on) state = PH_HMAP;
            else state = PH_RTYPE;
          end else begin
            rec_index++;
          end
        end
        PH_RTYPE: begin
          if (b == 8'd0) begin
            push_result(KIND_UNAVL, '0, '0, 1'b1);
            advance_sector();
          end else begin
            data_offset = '0;
            state = b[0] ? PH_DATA : PH_FILL;
          end
        end
        PH_DATA: begin
          if (int'(data_offset) + 1 >= (int'(BaseSize) << trk_size)) begin
            push_result(KIND_DATA, data_offset, b, 1'b1);
            data_offset = '0;
            advance_sector();
          end else begin
            push_result(KIND_DATA, data_offset, b, 1'b0);
            data_offset++;
          end
        end
        PH_FILL: begin
          push_result(KIND_FILL, '0, b, 1'b1);
          advance_sector();
        end
        default: state = PH_SKIP;
      endcase
    endfunction

    function void compare_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(sector_result_t got);
      sector_result_t want;
      if (expected.size() == 0) begin
        $error("result with nothing pending: kind %0d value %0d", got.kind, got.value);
        failures++;
        return;
      end
      want = expected.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("cylinder", want.cylinder, got.cylinder);
      compare_field("head_number", want.head_number, got.head_number);
      compare_field("sector_id", want.sector_id, got.sector_id);
      compare_field("size_code", want.size_code, got.size_code);
      compare_field("byte_offset", want.byte_offset, got.byte_offset);
      compare_field("value", want.value, got.value);
      compare_field("last", want.last, got.last);
      compare_field("max_cylinder", want.max_cylinder, got.max_cylinder);
      compare_field("max_head", want.max_head, got.max_head);
      compare_field("max_sectors", want.max_sectors, got.max_sectors);
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imd_pkg::*;
  import imd_track_check_pkg::*;

  localparam int RandomItems = 1300;
  localparam int IdleFreeTail = 300;
  localparam int DrainCycles = 8;
  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        new_image_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  cylinder_o;
  logic [5:0]  head_number_o;
  logic [7:0]  sector_id_o;
  logic [2:0]  size_code_o;
  logic [12:0] byte_offset_o;
  logic [7:0]  value_o;
  logic        last_o;
  logic [7:0]  max_cylinder_o;
  logic [5:0]  max_head_o;
  logic [7:0]  max_sectors_o;

  track_scoreboard board = new();
  sector_result_t  dut_result;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              cycle_count = 0;
  int              items_sent = 0;
  int              drop_after = -1;

  imd_disk_image_track_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .new_image_i   (new_image_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .cylinder_o    (cylinder_o),
    .head_number_o (head_number_o),
    .sector_id_o   (sector_id_o),
    .size_code_o   (size_code_o),
    .byte_offset_o (byte_offset_o),
    .value_o       (value_o),
    .last_o        (last_o),
    .max_cylinder_o(max_cylinder_o),
    .max_head_o    (max_head_o),
    .max_sectors_o (max_sectors_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always_comb begin
    dut_result.kind         = kind_o;
    dut_result.cylinder     = cylinder_o;
    dut_result.head_number  = head_number_o;
    dut_result.sector_id    = sector_id_o;
    dut_result.size_code    = size_code_o;
    dut_result.byte_offset  = byte_offset_o;
    dut_result.value        = value_o;
    dut_result.last         = last_o;
    dut_result.max_cylinder = max_cylinder_o;
    dut_result.max_head     = max_head_o;
    dut_result.max_sectors  = max_sectors_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && !out_stall_i) board.check_result(dut_result);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (drop_after == 0) return;
    if (drop_after > 0) drop_after--;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    new_image_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, restart);
    items_sent++;
  endtask

  task automatic send_header(input logic restart);
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (b == HeaderEnd);
      send_byte(b, restart && i == 0);
    end
    send_byte(HeaderEnd, restart && n == 0);
  endtask

  task automatic send_track(input logic [7:0] cyl, input logic [7:0] head_byte,
                            input logic [7:0] nsec, input logic [7:0] size_byte,
                            input int data_pct, input bit data_first);
    int size_eff;
    int pick;
    size_eff = (size_byte > 8'(MaxSizeCode)) ? int'(MaxSizeCode) : int'(size_byte);
    send_byte(8'($urandom), 1'b0);
    send_byte(cyl, 1'b0);
    send_byte(head_byte, 1'b0);
    send_byte(nsec, 1'b0);
    send_byte(size_byte, 1'b0);
    for (int i = 0; i < nsec; i++) send_byte(8'($urandom), 1'b0);
    if (head_byte[CylMapBit]) for (int i = 0; i < nsec; i++) send_byte(8'($urandom), 1'b0);
    if (head_byte[HeadMapBit]) for (int i = 0; i < nsec; i++) send_byte(8'($urandom), 1'b0);
    for (int i = 0; i < nsec; i++) begin
      pick = $urandom_range(0, 99);
      if ((data_first && i == 0) || pick < data_pct) begin
        send_byte({7'($urandom), 1'b1}, 1'b0);
        for (int j = 0; j < (int'(BaseSize) << size_eff); j++) send_byte(8'($urandom), 1'b0);
      end else if (pick < data_pct + (100 - data_pct) / 2) begin
        send_byte(8'd0, 1'b0);
      end else begin
        send_byte({7'($urandom_range(1, 127)), 1'b0}, 1'b0);
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic send_opening();
    logic [8:0] opening [22] = '{
      9'h149, 9'h01A,
      9'h005, 9'h0FF, 9'h0FF, 9'h002, 9'h007,
      9'h0FF, 9'h000, 9'h011, 9'h022, 9'h033, 9'h044,
      9'h000, 9'h0FE, 9'h0FF,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h11A
    };
    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
  endtask

  task automatic send_image();
    logic [7:0] nsec;
    logic [7:0] size_byte;
    int         r;
    drop_after = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : -1;
    send_header($urandom_range(0, 9) != 0);
    repeat ($urandom_range(1, 4)) begin
      nsec = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      r = $urandom_range(0, 9);
      size_byte = (r < 6) ? 8'd0 : (r < 8) ? 8'd1 : 8'($urandom);
      send_track(8'($urandom), 8'($urandom), nsec, size_byte,
                 (size_byte <= 8'd1) ? 15 : 0, 1'b0);
    end
    drop_after = -1;
  endtask

  task automatic send_noise();
    drop_after = -1;
    repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_opening();

    send_header(1'b1);
    send_track(8'($urandom), {2'b00, 6'($urandom)}, 8'd255, 8'hFF, 0, 1'b0);

    while (items_sent < RandomItems) begin
      if (items_sent > RandomItems - IdleFreeTail) idle_on = 1'b0;
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_image();
    end
    idle_on = 1'b0;
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/imd_pkg.sv
hw/rtl/imd_sector_map.sv
hw/rtl/imd_parse_fsm.sv
hw/rtl/imd_out_stage.sv
hw/rtl/imd_disk_image_track_parser.sv
tb/imd_track_check_pkg.sv
tb/tb_top.sv
